// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; the including module must have i_clk and i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational property, checked at every clock edge out of reset
`define PDL_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

// implication, consequent checked in the same cycle
`define PDL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication, consequent checked in the next cycle
`define PDL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/pdl_pkg.sv -----
// types and codes for the positional deque list
// no dependencies; used by the cell, the top level and the checker
package pdl_pkg;

    // wide enough for any element index up to the largest supported capacity
    localparam int IDX_W = 10;

    typedef enum logic [2:0] {
        OP_INS_POS  = 3'd0,
        OP_REM_POS  = 3'd1,
        OP_PUSH_F   = 3'd2,
        OP_PUSH_B   = 3'd3,
        OP_POP_F    = 3'd4,
        OP_POP_B    = 3'd5,
        OP_PEEK     = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_POS   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_INS,
        SH_REM
    } t_shift;

    // broadcast to every cell in the cycle an item is accepted
    typedef struct packed {
        t_shift             kind;
        logic [IDX_W-1:0]   pos;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GRP,
        S_FIN,
        S_OUT
    } t_state;

endpackage

// ----- rtl/pdl_cell.sv -----
// one storage cell of the list: holds the element at index K
// depends on pdl_pkg for the control struct
module pdl_cell #(
    parameter int K = 0
) (
    input  logic                        i_clk,
    input  pdl_pkg::t_cell_ctl          i_ctl,
    input  logic [31:0]                 i_left,
    input  logic [31:0]                 i_right,
    input  logic [31:0]                 i_value,
    input  logic [pdl_pkg::IDX_W-1:0]   i_tail,
    output logic [31:0]                 o_data,
    output logic [31:0]                 o_tap
);

    localparam logic [pdl_pkg::IDX_W-1:0] MY_IDX = pdl_pkg::IDX_W'(K);

    logic [31:0] r_data;
    logic [31:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.kind)
            pdl_pkg::SH_INS: begin
                if (MY_IDX == i_ctl.pos) begin
                    n_data = i_value;
                end else if (MY_IDX > i_ctl.pos) begin
                    n_data = i_left;
                end
            end
            pdl_pkg::SH_REM: begin
                // close the gap: this cell and all behind it take from the right
                if (MY_IDX >= i_ctl.pos) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = (MY_IDX == i_tail) ? r_data : 32'd0;

endmodule

// ----- rtl/positional_deque_list_unit.sv -----
// positional deque list: a row of CAPACITY cells that shift up or down together
// after the accepting edge the result passes the group OR reg, then the result reg
// one item is in flight until its result is taken; no new item is accepted before then
// the back value comes through a two-level registered OR tree over the cell taps
// reset (i_rst_n low, synchronous) empties the list and drops any pending result
// cell contents are not reset; only indices below the count are ever shown
module positional_deque_list_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_opcode,
    input  logic [6:0]          i_position,
    input  logic signed [31:0]  i_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_front_value,
    output logic signed [31:0]  o_back_value,
    output logic [6:0]          o_count,
    output logic                o_is_empty
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int XW  = (CW > 7) ? CW : 7;
    localparam int GRP = 8;
    localparam int NG  = (CAPACITY + GRP - 1) / GRP;
    localparam int IW  = pdl_pkg::IDX_W;

    pdl_pkg::t_state    r_state;
    pdl_pkg::t_state    n_state;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_cnt;
    logic [IW-1:0]      r_tail;
    pdl_pkg::t_cell_ctl w_ctl;
    pdl_pkg::t_status   w_status;
    logic [1:0]         r_status;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic [XW-1:0]      w_pos_x;
    logic [XW-1:0]      w_cnt_x;
    logic               w_load_out;
    logic [31:0]        w_data [CAPACITY];
    logic [31:0]        w_tap  [CAPACITY];
    logic [31:0]        r_grp  [NG];
    logic [31:0]        n_grp  [NG];
    logic [31:0]        w_back;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_full   = (r_cnt == CW'(CAPACITY));
    assign w_empty  = (r_cnt == '0);
    assign w_pos_x  = XW'(i_position);
    assign w_cnt_x  = XW'(r_cnt);

    // operation decode and status
    always_comb begin
        w_ctl.kind = pdl_pkg::SH_HOLD;
        w_ctl.pos  = '0;
        w_status   = pdl_pkg::ST_OK;
        n_cnt      = r_cnt;
        unique case (pdl_pkg::t_op'(i_opcode))
            pdl_pkg::OP_INS_POS: begin
                if (w_pos_x > w_cnt_x) begin
                    w_status = pdl_pkg::ST_POS;
                end else if (w_full) begin
                    w_status = pdl_pkg::ST_FULL;
                end else begin
                    w_ctl.kind = pdl_pkg::SH_INS;
                    w_ctl.pos  = IW'(i_position);
                    n_cnt      = r_cnt + 1'b1;
                end
            end
            pdl_pkg::OP_REM_POS: begin
                if (w_pos_x >= w_cnt_x) begin
                    w_status = pdl_pkg::ST_POS;
                end else begin
                    w_ctl.kind = pdl_pkg::SH_REM;
                    w_ctl.pos  = IW'(i_position);
                    n_cnt      = r_cnt - 1'b1;
                end
            end
            pdl_pkg::OP_PUSH_F: begin
                if (w_full) begin
                    w_status = pdl_pkg::ST_FULL;
                end else begin
                    w_ctl.kind = pdl_pkg::SH_INS;
                    n_cnt      = r_cnt + 1'b1;
                end
            end
            pdl_pkg::OP_PUSH_B: begin
                if (w_full) begin
                    w_status = pdl_pkg::ST_FULL;
                end else begin
                    w_ctl.kind = pdl_pkg::SH_INS;
                    w_ctl.pos  = IW'(r_cnt);
                    n_cnt      = r_cnt + 1'b1;
                end
            end
            pdl_pkg::OP_POP_F: begin
                if (w_empty) begin
                    w_status = pdl_pkg::ST_EMPTY;
                end else begin
                    w_ctl.kind = pdl_pkg::SH_REM;
                    n_cnt      = r_cnt - 1'b1;
                end
            end
            pdl_pkg::OP_POP_B: begin
                if (w_empty) begin
                    w_status = pdl_pkg::ST_EMPTY;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                w_status = pdl_pkg::ST_OK;
            end
        endcase
        if (!w_accept) begin
            w_ctl.kind = pdl_pkg::SH_HOLD;
        end
    end

    // row of cells
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [31:0] w_left;
        logic [31:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = 32'd0;
        end else begin : g_mid_l
            assign w_left = w_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_right = 32'd0;
        end else begin : g_mid_r
            assign w_right = w_data[k+1];
        end
        pdl_cell #(
            .K(k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_value (i_value),
            .i_tail  (r_tail),
            .o_data  (w_data[k]),
            .o_tap   (w_tap[k])
        );
    end

    // first tree level: OR of the taps in each group of eight
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = 32'd0;
            for (int j = 0; j < GRP; j++) begin
                if (g * GRP + j < CAPACITY) begin
                    n_grp[g] = n_grp[g] | w_tap[g * GRP + j];
                end
            end
        end
    end

    always_comb begin
        w_back = 32'd0;
        for (int g = 0; g < NG; g++) begin
            w_back = w_back | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pdl_pkg::S_GRP;
                end
            end
            pdl_pkg::S_GRP: n_state = pdl_pkg::S_FIN;
            pdl_pkg::S_FIN: n_state = pdl_pkg::S_OUT;
            pdl_pkg::S_OUT: begin
                if (i_out_ready) begin
                    n_state = pdl_pkg::S_IDLE;
                end
            end
            default: n_state = pdl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            pdl_pkg::S_IDLE: o_in_ready  = 1'b1;
            pdl_pkg::S_GRP:  o_in_ready  = 1'b0;
            pdl_pkg::S_FIN:  w_load_out  = 1'b1;
            pdl_pkg::S_OUT:  o_out_valid = 1'b1;
            default:         o_in_ready  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdl_pkg::S_IDLE;
            r_cnt   <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt  <= n_cnt;
                r_tail <= IW'(n_cnt - 1'b1);
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
        end
        if (w_load_out) begin
            o_status      <= r_status;
            o_front_value <= w_empty ? 32'sd0 : w_data[0];
            o_back_value  <= w_empty ? 32'sd0 : w_back;
            o_count       <= w_cnt_x[6:0];
            o_is_empty    <= w_empty;
        end
    end

endmodule

// ----- rtl/pdl_checker.sv -----
// port-level checks for positional_deque_list_unit, attached by bind
// depends on pdl_pkg and assert_macros.svh
`include "assert_macros.svh"

module pdl_port_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic [1:0]          o_status,
    input  logic signed [31:0]  o_front_value,
    input  logic signed [31:0]  o_back_value,
    input  logic [6:0]          o_count,
    input  logic                o_is_empty
);

    logic        w_ends_zero;
    logic        w_underflow;
    logic        w_fill_err;
    logic [73:0] w_payload;

    assign w_ends_zero = (o_count == 7'd0) && (o_front_value == 32'sd0)
                         && (o_back_value == 32'sd0);
    assign w_underflow = (o_status == pdl_pkg::ST_EMPTY);
    assign w_fill_err  = w_underflow || (o_status == pdl_pkg::ST_FULL);
    assign w_payload   = {o_status, o_front_value, o_back_value, o_count, o_is_empty};

    // one item in flight: no new item while a result waits
    `PDL_ASSERT_ALWAYS(a_no_overlap, !(o_out_valid && o_in_ready))

    // an empty list shows zero count and zero ends
    `PDL_ASSERT_SAME(a_empty_zero, o_out_valid && o_is_empty, w_ends_zero)

    // underflow only on an empty list, overflow never on one
    `PDL_ASSERT_SAME(a_status_fill, o_out_valid && w_fill_err, w_underflow == o_is_empty)

    // a stalled result holds
    `PDL_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(w_payload))

endmodule

bind positional_deque_list_unit pdl_port_checker u_pdl_port_checker (.*);
